/* rtl/assert_macros.svh */
// Assertion helpers used by the accumulator design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant check failed");
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`else
`define CHK_ALWAYS(label, clk, rst_n, expr)
`define CHK_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rima_pkg.sv */
package rima_pkg;

	localparam int MAX_PIXELS     = 1048576;
	localparam int INTENSITY_BITS = 16;
	localparam int CNT_W          = $clog2(MAX_PIXELS + 1);

	localparam int DIV_W     = 56;
	localparam int DIV_RADIX = 4;
	localparam int DIV_STEPS = DIV_W / DIV_RADIX;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [15:0] INT_MASK = 16'((32'd1 << INTENSITY_BITS) - 32'd1);
	localparam logic [51:0] CAP52    = '1;
	localparam logic [47:0] CAP48    = '1;
	localparam logic [35:0] CAP36    = '1;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [15:0] intensity;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        first_pixel;
	} pixel_t;

	typedef struct packed {
		logic [20:0]        pixel_count;
		logic [31:0]        mean_out;
		logic [62:0]        second_moment;
		logic signed [63:0] third_moment;
		logic [62:0]        fourth_moment;
		logic [15:0]        min_intensity;
		logic [15:0]        max_intensity;
		logic [51:0]        energy_sum;
		logic [47:0]        variance_out;
		logic [51:0]        abs_dev_sum;
		logic [35:0]        x_sum;
		logic [35:0]        y_sum;
	} result_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic [5:0]         sh;
	} mul_req_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic [CNT_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] res;
	} unit_rsp_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic [63:0] u;
		u = v;
		return u[63] ? (~u + 64'd1) : u;
	endfunction

	function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

endpackage

/* rtl/roi_intensity_moment_accumulator.sv */
// Channel  Signals                             Direction  Item
// pixel    pixel_valid, pixel_stall, pixel     in         intensity, position, first flag
// result   result_valid, result_stall, result  out        count, mean, moments, sums
//
// A pixel goes through preparation, seventeen products on the shared multiplier and four
// divisions on the serial divider (four quotient bits a cycle), three by the new count
// and one by the count less one, then commit and output. Once the count is full a pixel
// goes from preparation straight to output. The next pixel can be taken in the cycle
// after the result is loaded. pixel_stall is high while a pixel is in work; a pixel is
// taken while the previous result still waits under result_stall. Reset clears every
// accumulator at once; min starts at all ones.
`include "assert_macros.svh"

module roi_intensity_moment_accumulator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	input  rima_pkg::pixel_t  pixel,
	output logic              result_valid,
	input  logic              result_stall,
	output rima_pkg::result_t result
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_ISSUE, ST_WAIT, ST_COMMIT, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_DN, OP_DP_MUL, OP_DP_DIV, OP_T1, OP_T1DN, OP_DN2, OP_POLY,
		OP_A1, OP_A2, OP_B1, OP_B2, OP_C1, OP_C2, OP_E1, OP_E2, OP_F1, OP_F2,
		OP_G, OP_VADD, OP_VQ, OP_EN
	} step_t;

	state_t                        state_q;
	step_t                         step_q;
	logic                          out_valid_q;
	rima_pkg::result_t             out_q;

	logic [rima_pkg::CNT_W-1:0]    count_q;
	logic [31:0]                   mean_q;
	logic signed [63:0]            m2_q;
	logic signed [63:0]            m3_q;
	logic signed [63:0]            m4_q;
	logic [15:0]                   min_q;
	logic [15:0]                   max_q;
	logic [51:0]                   energy_q;
	logic [47:0]                   var_q;
	logic [51:0]                   absdev_q;
	logic [35:0]                   xsum_q;
	logic [35:0]                   ysum_q;

	logic [15:0]                   inten_q;
	logic [15:0]                   px_q;
	logic [15:0]                   py_q;
	logic [rima_pkg::CNT_W-1:0]    n_q;
	logic signed [33:0]            d_q;
	logic signed [33:0]            dn_q;
	logic signed [33:0]            dp_q;
	logic [31:0]                   mn_q;
	logic signed [63:0]            t1_q;
	logic signed [63:0]            t1dn_q;
	logic signed [63:0]            dn2_q;
	logic signed [41:0]            poly_q;
	logic signed [63:0]            tmp_q;
	logic signed [63:0]            m4n_q;
	logic signed [63:0]            m3n_q;
	logic [48:0]                   vadd_q;
	logic [47:0]                   vq_q;
	logic [31:0]                   en_inc_q;

	rima_pkg::mul_req_t            mul_req;
	rima_pkg::div_req_t            div_req;
	rima_pkg::unit_rsp_t           mul_rsp;
	rima_pkg::unit_rsp_t           div_rsp;

	logic                          use_div;
	logic signed [63:0]            mul_a;
	logic signed [63:0]            mul_b;
	logic [5:0]                    mul_sh;
	logic signed [63:0]            div_num;
	logic [rima_pkg::CNT_W-1:0]    div_den;
	logic                          unit_done;
	logic signed [63:0]            unit_res;

	logic signed [63:0]            d_ext;
	logic signed [63:0]            dn_ext;
	logic signed [63:0]            dp_ext;
	logic signed [63:0]            n_ext;
	logic signed [63:0]            p_ext;
	logic signed [63:0]            inten_ext;
	logic [31:0]                   x_val;
	logic [34:0]                   mn_sum;
	logic [31:0]                   mn_clamp;

	logic signed [63:0]            m2_sum;
	logic [47:0]                   v_diff;
	logic [49:0]                   v_sum;
	logic [32:0]                   ad;
	logic [31:0]                   ad_mag;
	logic [52:0]                   absdev_sum;
	logic [52:0]                   energy_sum;
	logic [36:0]                   xsum_sum;
	logic [36:0]                   ysum_sum;

	assign x_val     = {inten_q, 16'd0};
	assign d_ext     = 64'(d_q);
	assign dn_ext    = 64'(dn_q);
	assign dp_ext    = 64'(dp_q);
	assign n_ext     = $signed(64'(n_q));
	assign p_ext     = $signed(64'(count_q));
	assign inten_ext = $signed(64'(inten_q));

	rima_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	rima_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Operands for the current step of the update sequence.
	always_comb begin
		use_div = 1'b0;
		mul_a   = d_ext;
		mul_b   = d_ext;
		mul_sh  = 6'd0;
		div_num = d_ext;
		div_den = n_q;
		unique case (step_q)
			OP_DN:     use_div = 1'b1;
			OP_DP_MUL: mul_b = p_ext;
			OP_DP_DIV: begin
				use_div = 1'b1;
				div_num = tmp_q;
			end
			OP_T1: begin
				mul_b  = dp_ext;
				mul_sh = 6'd24;
			end
			OP_T1DN: begin
				mul_a  = t1_q;
				mul_b  = dn_ext;
				mul_sh = 6'd16;
			end
			OP_DN2: begin
				mul_a  = dn_ext;
				mul_b  = dn_ext;
				mul_sh = 6'd16;
			end
			OP_POLY: begin
				mul_a = n_ext;
				mul_b = n_ext - 64'sd3;
			end
			OP_A1: begin
				mul_a  = t1dn_q;
				mul_b  = dn_ext;
				mul_sh = 6'd48;
			end
			OP_A2: begin
				mul_a = tmp_q;
				mul_b = 64'(poly_q);
			end
			OP_B1: begin
				mul_a  = dn2_q;
				mul_b  = m2_q;
				mul_sh = 6'd48;
			end
			OP_B2: begin
				mul_a = tmp_q;
				mul_b = 64'sd6;
			end
			OP_C1: begin
				mul_a  = dn_ext;
				mul_b  = m3_q;
				mul_sh = 6'd32;
			end
			OP_C2: begin
				mul_a = tmp_q;
				mul_b = -64'sd4;
			end
			OP_E1: begin
				mul_a  = t1_q;
				mul_b  = dn_ext;
				mul_sh = 6'd32;
			end
			OP_E2: begin
				mul_a = tmp_q;
				mul_b = n_ext - 64'sd2;
			end
			OP_F1: begin
				mul_a  = m2_q;
				mul_b  = dn_ext;
				mul_sh = 6'd32;
			end
			OP_F2: begin
				mul_a = tmp_q;
				mul_b = -64'sd3;
			end
			OP_G:      mul_sh = 6'd16;
			OP_VADD: begin
				use_div = 1'b1;
				div_num = tmp_q;
			end
			OP_VQ: begin
				use_div = 1'b1;
				div_num = $signed(64'(var_q));
				div_den = n_q - 1'b1;
			end
			OP_EN: begin
				mul_a = inten_ext;
				mul_b = inten_ext;
			end
			default: use_div = 1'b0;
		endcase
	end

	assign mul_req.start = (state_q == ST_ISSUE) && !use_div;
	assign mul_req.a     = mul_a;
	assign mul_req.b     = mul_b;
	assign mul_req.sh    = mul_sh;
	assign div_req.start = (state_q == ST_ISSUE) && use_div;
	assign div_req.num   = div_num;
	assign div_req.den   = div_den;

	assign unit_done = use_div ? div_rsp.done : mul_rsp.done;
	assign unit_res  = use_div ? div_rsp.res : mul_rsp.res;

	// New mean, clamped to the unsigned 32-bit range.
	always_comb begin
		mn_sum = {3'b000, mean_q} + {unit_res[33], unit_res[33:0]};
		if (mn_sum[34]) begin
			mn_clamp = '0;
		end else if (mn_sum[33:32] != 2'b00) begin
			mn_clamp = '1;
		end else begin
			mn_clamp = mn_sum[31:0];
		end
	end

	always_comb begin
		m2_sum     = rima_pkg::add_sat64(m2_q, t1_q);
		v_diff     = var_q - vq_q;
		v_sum      = {2'b00, v_diff} + {1'b0, vadd_q};
		ad         = {1'b0, x_val} - {1'b0, mn_q};
		ad_mag     = ad[32] ? 32'(~ad + 33'd1) : ad[31:0];
		absdev_sum = {1'b0, absdev_q} + 53'(ad_mag);
		energy_sum = {1'b0, energy_q} + 53'(en_inc_q);
		xsum_sum   = {1'b0, xsum_q} + 37'(px_q);
		ysum_sum   = {1'b0, ysum_q} + 37'(py_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= OP_DN;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			mean_q      <= '0;
			m2_q        <= '0;
			m3_q        <= '0;
			m4_q        <= '0;
			min_q       <= '1;
			max_q       <= '0;
			energy_q    <= '0;
			var_q       <= '0;
			absdev_q    <= '0;
			xsum_q      <= '0;
			ysum_q      <= '0;
		end else begin
			if (out_valid_q && !result_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pixel_valid) begin
						state_q <= ST_PREP;
						// A new region starts from the reset values.
						if (pixel.first_pixel) begin
							count_q  <= '0;
							mean_q   <= '0;
							m2_q     <= '0;
							m3_q     <= '0;
							m4_q     <= '0;
							min_q    <= '1;
							max_q    <= '0;
							energy_q <= '0;
							var_q    <= '0;
							absdev_q <= '0;
							xsum_q   <= '0;
							ysum_q   <= '0;
						end
					end
				end
				ST_PREP: begin
					step_q <= OP_DN;
					if (count_q >= rima_pkg::CNT_W'(rima_pkg::MAX_PIXELS)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (unit_done) begin
						if (step_q == OP_EN) begin
							state_q <= ST_COMMIT;
						end else begin
							step_q  <= step_t'(step_q + 5'd1);
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_COMMIT: begin
					count_q  <= n_q;
					mean_q   <= mn_q;
					m2_q     <= m2_sum[63] ? 64'sd0 : m2_sum;
					m3_q     <= m3n_q;
					m4_q     <= m4n_q[63] ? 64'sd0 : m4n_q;
					if (inten_q < min_q) begin
						min_q <= inten_q;
					end
					if (inten_q > max_q) begin
						max_q <= inten_q;
					end
					energy_q <= (energy_sum > 53'(rima_pkg::CAP52)) ? rima_pkg::CAP52
							: energy_sum[51:0];
					if (n_q == rima_pkg::CNT_W'(1)) begin
						var_q <= '0;
					end else begin
						var_q <= (v_sum > 50'(rima_pkg::CAP48)) ? rima_pkg::CAP48
								: v_sum[47:0];
					end
					absdev_q <= (absdev_sum > 53'(rima_pkg::CAP52)) ? rima_pkg::CAP52
							: absdev_sum[51:0];
					xsum_q   <= (xsum_sum > 37'(rima_pkg::CAP36)) ? rima_pkg::CAP36
							: xsum_sum[35:0];
					ysum_q   <= (ysum_sum > 37'(rima_pkg::CAP36)) ? rima_pkg::CAP36
							: ysum_sum[35:0];
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !result_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pixel_valid) begin
			inten_q <= pixel.intensity & rima_pkg::INT_MASK;
			px_q    <= pixel.pos_x;
			py_q    <= pixel.pos_y;
		end
		if (state_q == ST_PREP) begin
			n_q <= count_q + 1'b1;
			d_q <= $signed({2'b00, x_val}) - $signed({2'b00, mean_q});
		end
		if (state_q == ST_WAIT && unit_done) begin
			case (step_q)
				OP_DN: begin
					dn_q <= unit_res[33:0];
					mn_q <= mn_clamp;
				end
				OP_DP_DIV: dp_q   <= unit_res[33:0];
				OP_T1:     t1_q   <= unit_res;
				OP_T1DN:   t1dn_q <= unit_res;
				OP_DN2:    dn2_q  <= unit_res;
				OP_POLY:   poly_q <= 42'(unit_res + 64'sd3);
				OP_A2:     m4n_q  <= rima_pkg::add_sat64(m4_q, unit_res);
				OP_B2, OP_C2: m4n_q <= rima_pkg::add_sat64(m4n_q, unit_res);
				OP_E2:     m3n_q  <= rima_pkg::add_sat64(m3_q, unit_res);
				OP_F2:     m3n_q  <= rima_pkg::add_sat64(m3n_q, unit_res);
				OP_VADD:   vadd_q <= unit_res[48:0];
				OP_VQ:     vq_q   <= unit_res[47:0];
				OP_EN:     en_inc_q <= unit_res[31:0];
				default:   tmp_q  <= unit_res;
			endcase
		end
		if (state_q == ST_OUT && (!out_valid_q || !result_stall)) begin
			out_q.pixel_count   <= 21'(count_q);
			out_q.mean_out      <= mean_q;
			out_q.second_moment <= m2_q[62:0];
			out_q.third_moment  <= m3_q;
			out_q.fourth_moment <= m4_q[62:0];
			out_q.min_intensity <= min_q;
			out_q.max_intensity <= max_q;
			out_q.energy_sum    <= energy_q;
			out_q.variance_out  <= var_q;
			out_q.abs_dev_sum   <= absdev_q;
			out_q.x_sum         <= xsum_q;
			out_q.y_sum         <= ysum_q;
		end
	end

	assign pixel_stall  = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	`CHK_IMPLY(a_done_in_wait, clk, arst_n, mul_rsp.done || div_rsp.done, state_q == ST_WAIT)
	`CHK_IMPLY(a_out_after_work, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_OUT)
	`CHK_ALWAYS(a_count_cap, clk, arst_n, count_q <= rima_pkg::CNT_W'(rima_pkg::MAX_PIXELS))
	`CHK_IMPLY(a_min_le_max, clk, arst_n, count_q != '0, min_q <= max_q)

endmodule

/* rtl/rima_mul.sv */
module rima_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  rima_pkg::mul_req_t  req,
	output rima_pkg::unit_rsp_t rsp
);

	typedef enum logic [2:0] {PH_IDLE, PH_PP, PH_ACC, PH_ROUND, PH_SHIFT} phase_t;

	phase_t             phase_q;
	logic [1:0]         cnt_q;
	logic               pp_vld_s1;
	logic               done_q;
	logic [63:0]        ua_q;
	logic [63:0]        ub_q;
	logic               neg_q;
	logic [5:0]         sh_q;
	logic [63:0]        pp_s1;
	logic [1:0]         off_s1;
	logic [127:0]       acc_q;
	logic signed [63:0] res_q;

	logic [31:0]        a_half;
	logic [31:0]        b_half;
	logic [127:0]       pp_ext;
	logic [127:0]       rnd;
	logic [127:0]       shifted;
	logic signed [63:0] sat_res;

	always_comb begin
		a_half = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		b_half = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		case (off_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			default: pp_ext = {pp_s1, 64'd0};
		endcase
		rnd = (sh_q == 6'd0) ? 128'd0 : (128'd1 << (sh_q - 6'd1));
		shifted = acc_q >> sh_q;
		// A magnitude of 2^63 or more saturates to the signed limit.
		if (shifted[127:63] != '0) begin
			sat_res = neg_q ? rima_pkg::S64_MIN : rima_pkg::S64_MAX;
		end else begin
			sat_res = neg_q ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (phase_q == PH_SHIFT);
			unique case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q   <= PH_PP;
						cnt_q     <= '0;
						pp_vld_s1 <= 1'b0;
					end
				end
				PH_PP: begin
					pp_vld_s1 <= 1'b1;
					cnt_q     <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						phase_q <= PH_ACC;
					end
				end
				PH_ACC: begin
					pp_vld_s1 <= 1'b0;
					phase_q   <= PH_ROUND;
				end
				PH_ROUND: phase_q <= PH_SHIFT;
				PH_SHIFT: phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && req.start) begin
			ua_q  <= rima_pkg::mag64(req.a);
			ub_q  <= rima_pkg::mag64(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			sh_q  <= req.sh;
			acc_q <= '0;
		end
		if (phase_q == PH_PP) begin
			pp_s1  <= 64'(a_half) * 64'(b_half);
			off_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		end
		if (pp_vld_s1) begin
			acc_q <= acc_q + pp_ext;
		end
		if (phase_q == PH_ROUND) begin
			acc_q <= acc_q + rnd;
		end
		if (phase_q == PH_SHIFT) begin
			res_q <= sat_res;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

/* rtl/rima_div.sv */
module rima_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rima_pkg::div_req_t  req,
	output rima_pkg::unit_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [rima_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [rima_pkg::DIV_W-1:0]       dvd_q;
	logic [rima_pkg::CNT_W:0]         rem_q;
	logic [rima_pkg::CNT_W-1:0]       den_q;
	logic                             neg_q;
	logic signed [63:0]               res_q;

	logic [63:0]                      num_mag;
	logic [rima_pkg::DIV_W-1:0]       q_nx;
	logic [rima_pkg::CNT_W:0]         r_nx;
	logic [rima_pkg::CNT_W:0]         trial;
	logic                             last;

	// Rounding to nearest is folded in by adding half the divisor up front.
	assign num_mag = rima_pkg::mag64(req.num) + 64'(req.den >> 1);
	assign last    = (cnt_q == rima_pkg::DIV_CNT_W'(rima_pkg::DIV_STEPS - 1));

	always_comb begin
		r_nx  = rem_q;
		q_nx  = dvd_q;
		trial = '0;
		for (int k = 0; k < rima_pkg::DIV_RADIX; k++) begin
			trial = {r_nx[rima_pkg::CNT_W-1:0], q_nx[rima_pkg::DIV_W-1]};
			q_nx  = {q_nx[rima_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial   = trial - {1'b0, den_q};
				q_nx[0] = 1'b1;
			end
			r_nx = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			dvd_q <= num_mag[rima_pkg::DIV_W-1:0];
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[63];
		end else if (busy_q) begin
			dvd_q <= q_nx;
			rem_q <= r_nx;
			if (last) begin
				res_q <= neg_q ? -$signed(64'(q_nx)) : $signed(64'(q_nx));
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

/* bench/roi_intensity_moment_accumulator_tb.sv */
`timescale 1ns / 1ps

module roi_intensity_moment_accumulator_tb;

	localparam int          CYCLE_LIMIT  = 1500000;
	localparam int          RANDOM_ITEMS = 1500;
	localparam int          SETTLE       = 300;
	localparam logic [63:0] MAG_TOP      = 64'h8000_0000_0000_0000;
	localparam logic [63:0] FULL_COUNT   = 64'd1048576;

	typedef struct {
		rima_pkg::pixel_t  px;
		bit                typed;
		rima_pkg::result_t want;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              pixel_valid;
	logic              pixel_stall;
	rima_pkg::pixel_t  pixel;
	logic              result_valid;
	logic              result_stall;
	rima_pkg::result_t result;

	roi_intensity_moment_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Predictor state.
	logic [63:0]        acc_count;
	logic [31:0]        acc_mean;
	logic signed [63:0] acc_m2, acc_m3, acc_m4;
	logic [15:0]        acc_min, acc_max;
	logic [63:0]        acc_energy, acc_var, acc_absdev, acc_xsum, acc_ysum;

	rima_pkg::result_t expected_results[$];
	dir_row_t          dir_rows[$];
	int                errors;
	int                results_seen;
	int                regions;
	int                cycles;
	int                hold_left;
	int                burst_left;
	bit                drain_next;
	int                region_len_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [63:0] magnitude(input logic signed [63:0] v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] with_sign(input bit neg, input logic [63:0] mag);
		if (neg)
			return (mag >= MAG_TOP) ? 64'sh8000_0000_0000_0000 : -$signed(mag);
		return (mag >= MAG_TOP) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(mag);
	endfunction

	// Exact product, rounded shift, then saturation to signed 64 bits.
	function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
			input logic signed [63:0] b, input int sh);
		logic [127:0] pr;
		logic [63:0]  lo;
		pr = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		if (sh > 0)
			pr = (pr + (128'd1 << (sh - 1))) >> sh;
		lo = (pr[127:64] != 0) ? MAG_TOP : pr[63:0];
		return with_sign((a < 0) != (b < 0), lo);
	endfunction

	function automatic logic signed [63:0] div_nearest(input logic signed [63:0] a,
			input logic [63:0] n);
		logic [64:0] m;
		m = {1'b0, magnitude(a)};
		return with_sign(a < 0, 64'((m + {1'b0, n >> 1}) / {1'b0, n}));
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic logic [63:0] cap_add(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] cap);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, cap}) ? cap : s[63:0];
	endfunction

	function automatic void clear_accumulators();
		acc_count  = 0;
		acc_mean   = 0;
		acc_m2     = 0;
		acc_m3     = 0;
		acc_m4     = 0;
		acc_min    = 16'hFFFF;
		acc_max    = 0;
		acc_energy = 0;
		acc_var    = 0;
		acc_absdev = 0;
		acc_xsum   = 0;
		acc_ysum   = 0;
	endfunction

	function automatic rima_pkg::result_t accumulate_pixel(input rima_pkg::pixel_t px);
		logic [63:0]        inten, p, n, vkeep, vadd;
		logic signed [63:0] x, d, dn, dp, t1, t1dn, dn2, poly, m4n, m3n, m2n, mn, ad;
		rima_pkg::result_t  r;
		inten = {48'd0, px.intensity};
		if (px.first_pixel)
			clear_accumulators();
		if (acc_count < FULL_COUNT) begin
			p    = acc_count;
			n    = p + 1;
			x    = $signed(inten << 16);
			d    = x - $signed({32'd0, acc_mean});
			dn   = div_nearest(d, n);
			dp   = div_nearest(d * $signed(p), n);
			t1   = mul_round(d, dp, 24);
			t1dn = mul_round(t1, dn, 16);
			dn2  = mul_round(dn, dn, 16);
			poly = $signed(n * n + 3 - 3 * n);
			m4n  = sat_add(acc_m4, mul_round(mul_round(t1dn, dn, 48), poly, 0));
			m4n  = sat_add(m4n, mul_round(mul_round(dn2, acc_m2, 48), 64'sd6, 0));
			m4n  = sat_add(m4n, mul_round(mul_round(dn, acc_m3, 32), -64'sd4, 0));
			m3n  = sat_add(acc_m3, mul_round(mul_round(t1, dn, 32), $signed(n) - 2, 0));
			m3n  = sat_add(m3n, mul_round(mul_round(acc_m2, dn, 32), -64'sd3, 0));
			m2n  = sat_add(acc_m2, t1);
			acc_m4 = (m4n < 0) ? 0 : m4n;
			acc_m3 = m3n;
			acc_m2 = (m2n < 0) ? 0 : m2n;
			if (n >= 2) begin
				vkeep   = acc_var - 64'(div_nearest($signed(acc_var), n - 1));
				vadd    = 64'(div_nearest(mul_round(d, d, 16), n));
				acc_var = cap_add(vkeep, vadd, 64'hFFFF_FFFF_FFFF);
			end else begin
				acc_var = 0;
			end
			mn = $signed({32'd0, acc_mean}) + dn;
			if (mn < 0)
				mn = 0;
			if (mn > 64'sh0_FFFF_FFFF)
				mn = 64'sh0_FFFF_FFFF;
			acc_mean = mn[31:0];
			if (px.intensity < acc_min)
				acc_min = px.intensity;
			if (px.intensity > acc_max)
				acc_max = px.intensity;
			acc_energy = cap_add(acc_energy, inten * inten, 64'h000F_FFFF_FFFF_FFFF);
			ad         = x - mn;
			acc_absdev = cap_add(acc_absdev, magnitude(ad), 64'h000F_FFFF_FFFF_FFFF);
			acc_xsum   = cap_add(acc_xsum, {48'd0, px.pos_x}, 64'h0F_FFFF_FFFF);
			acc_ysum   = cap_add(acc_ysum, {48'd0, px.pos_y}, 64'h0F_FFFF_FFFF);
			acc_count  = n;
		end
		r.pixel_count   = acc_count[20:0];
		r.mean_out      = acc_mean;
		r.second_moment = acc_m2[62:0];
		r.third_moment  = acc_m3;
		r.fourth_moment = acc_m4[62:0];
		r.min_intensity = acc_min;
		r.max_intensity = acc_max;
		r.energy_sum    = acc_energy[51:0];
		r.variance_out  = acc_var[47:0];
		r.abs_dev_sum   = acc_absdev[51:0];
		r.x_sum         = acc_xsum[35:0];
		r.y_sum         = acc_ysum[35:0];
		return r;
	endfunction

	function automatic rima_pkg::pixel_t pix(input logic [15:0] i, input logic [15:0] x,
			input logic [15:0] y, input logic f);
		rima_pkg::pixel_t px;
		px.intensity   = i;
		px.pos_x       = x;
		px.pos_y       = y;
		px.first_pixel = f;
		return px;
	endfunction

	// A region of one pixel: the mean is the sample and every moment is zero.
	function automatic rima_pkg::result_t lone_pixel(input logic [15:0] i,
			input logic [15:0] x, input logic [15:0] y);
		rima_pkg::result_t r;
		r               = '0;
		r.pixel_count   = 21'd1;
		r.mean_out      = {i, 16'd0};
		r.min_intensity = i;
		r.max_intensity = i;
		r.energy_sum    = 52'(i) * 52'(i);
		r.x_sum         = 36'(x);
		r.y_sum         = 36'(y);
		return r;
	endfunction

	// True on the first item of a freshly drawn region in nine draws out of ten, so that most regions open cleanly.
	function automatic bit left_is_new(input int left);
		bit fresh;
		fresh = (left > region_len_seen) || (region_len_seen == 0);
		region_len_seen = left - 1;
		return fresh && ($urandom_range(0, 9) != 0);
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			$display("Result %0d: %s is %h, expected %h", results_seen, field, got, want);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rima_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("Result %0d arrived with nothing expected", results_seen);
				errors++;
			end else begin
				want = expected_results.pop_front();
				report_mismatch("pixel_count", 64'(result.pixel_count), 64'(want.pixel_count));
				report_mismatch("mean_out", 64'(result.mean_out), 64'(want.mean_out));
				report_mismatch("second_moment", 64'(result.second_moment),
					64'(want.second_moment));
				report_mismatch("third_moment", result.third_moment, want.third_moment);
				report_mismatch("fourth_moment", 64'(result.fourth_moment),
					64'(want.fourth_moment));
				report_mismatch("min_intensity", 64'(result.min_intensity),
					64'(want.min_intensity));
				report_mismatch("max_intensity", 64'(result.max_intensity),
					64'(want.max_intensity));
				report_mismatch("energy_sum", 64'(result.energy_sum), 64'(want.energy_sum));
				report_mismatch("variance_out", 64'(result.variance_out),
					64'(want.variance_out));
				report_mismatch("abs_dev_sum", 64'(result.abs_dev_sum), 64'(want.abs_dev_sum));
				report_mismatch("x_sum", 64'(result.x_sum), 64'(want.x_sum));
				report_mismatch("y_sum", 64'(result.y_sum), 64'(want.y_sum));
			end
			results_seen++;
		end
	end

	// The receiver changes its stall habit after a randomly drawn span; a long hold
	// requested by the sender side overrides it.
	initial begin
		int mode;
		int span;
		mode = 0;
		span = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(50, 300);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 1) == 1);
					2: result_stall <= ($urandom_range(0, 9) < 8);
					default: result_stall <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// Called at a falling edge; returns at the falling edge where the next item may go.
	task automatic send_pixel(input rima_pkg::pixel_t px, input bit typed,
			input rima_pkg::result_t want);
		rima_pkg::result_t r;
		int                gap;
		pixel       <= px;
		pixel_valid <= 1'b1;
		do
			@(posedge clk);
		while (pixel_stall);
		r = accumulate_pixel(px);
		expected_results.push_back(typed ? want : r);
		if (px.first_pixel)
			regions++;
		@(negedge clk);
		if (drain_next) begin
			drain_next = 0;
			pixel_valid <= 1'b0;
			while (expected_results.size() != 0)
				@(negedge clk);
			repeat (SETTLE) @(negedge clk);
		end else if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	initial begin
		rima_pkg::pixel_t px;
		int               sent;
		int               left;
		int               kind;
		int               base;
		logic [15:0]      inten;
		arst_n          = 1'b0;
		pixel_valid     = 1'b0;
		pixel           = '0;
		result_stall    = 1'b0;
		errors          = 0;
		results_seen    = 0;
		regions         = 0;
		cycles          = 0;
		hold_left       = 0;
		burst_left      = 0;
		drain_next      = 0;
		region_len_seen = 0;
		clear_accumulators();

		dir_rows.push_back('{pix(16'd1234, 16'd5, 16'd6, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1,
			lone_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF)});
		dir_rows.push_back('{pix(16'd0, 16'd0, 16'd0, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'hFFFF, 16'hFFFF, 16'd0, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd0, 16'd0, 16'hFFFF, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'hFFFF, 16'h5555, 16'hAAAA, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd0, 16'hAAAA, 16'h5555, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd0, 16'd1, 16'd1, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd0, 16'd0, 16'd0, 1'b1), 1,
			lone_pixel(16'd0, 16'd0, 16'd0)});
		dir_rows.push_back('{pix(16'd1, 16'd1, 16'd1, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'h8000, 16'h8000, 16'h8000, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'h5555, 16'h7FFF, 16'h0001, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'hAAAA, 16'h0001, 16'h7FFF, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd300, 16'hFFFF, 16'd0, 1'b1), 1,
			lone_pixel(16'd300, 16'hFFFF, 16'd0)});
		dir_rows.push_back('{pix(16'd300, 16'd2, 16'd3, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd300, 16'd4, 16'd5, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd301, 16'd6, 16'd7, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd299, 16'd8, 16'd9, 1'b0), 0, '0});
		dir_rows.push_back('{pix(16'd7, 16'd10, 16'd11, 1'b1), 1,
			lone_pixel(16'd7, 16'd10, 16'd11)});
		dir_rows.push_back('{pix(16'hFFFE, 16'hFFFE, 16'hFFFE, 1'b1), 1,
			lone_pixel(16'hFFFE, 16'hFFFE, 16'hFFFE)});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);

		// Regions of random size; most are well formed, a few carry a stray first flag.
		sent = 0;
		left = 0;
		kind = 0;
		base = 0;
		while (sent < RANDOM_ITEMS) begin
			if (left == 0) begin
				left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250)
					: $urandom_range(1, 30);
				kind = $urandom_range(0, 3);
				base = $urandom_range(0, 65535);
			end
			case (kind)
				0: inten = 16'($urandom_range(0, 65535));
				1: inten = 16'(base) ^ 16'($urandom_range(0, 255));
				2: inten = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				default: inten = 16'($urandom_range(0, 15));
			endcase
			px = pix(inten, 16'($urandom), 16'($urandom), 1'b0);
			if (left == 1 || $urandom_range(0, 19) == 0)
				px.first_pixel = $urandom_range(0, 1);
			// First pixel of the next region is flagged on the item that opens it.
			if (left > 0 && px.first_pixel == 0 && sent > 0 && left_is_new(left))
				px.first_pixel = 1'b1;
			left--;
			if (sent == 600)
				hold_left = 3000;
			if (sent == 1100)
				drain_next = 1;
			send_pixel(px, 0, '0);
			sent++;
		end
		pixel_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d pixels in %0d flagged regions, %0d results checked",
			sent + dir_rows.size(), regions, results_seen);
		$display("Mismatches found: %0d", errors);
		if (errors == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/rima_pkg.sv
rtl/rima_mul.sv
rtl/rima_div.sv
rtl/roi_intensity_moment_accumulator.sv
bench/roi_intensity_moment_accumulator_tb.sv
